/* design/pin_lockout_access_gate_unit_defines.svh */
// Assertion macros shared by the PIN lockout access gate files.
`ifndef PIN_LOCKOUT_ACCESS_GATE_UNIT_DEFINES_SVH
`define PIN_LOCKOUT_ACCESS_GATE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, muted while reset is high
`define PLAG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// clocked check that also holds through reset
`define PLAG_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define PLAG_ASSERT(lbl, prop, msg)
`define PLAG_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* design/plag_pkg.sv */
// Shared types, codes and access tables for the PIN lockout access gate.
package plag_pkg;

   localparam int CMD_W       = 3;
   localparam int TIME_W      = 48;
   localparam int PIN_W       = 48;
   localparam int PIN_LEN_W   = 9;
   localparam int CODE_W      = 8;
   localparam int CHAR_W      = 4;
   localparam int STATUS_W    = 3;
   localparam int LEVEL_W     = 2;
   localparam int COUNT_W     = 8;
   localparam int MAX_ATT_W   = 8;
   localparam int LOCK_T_W    = 40;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 48;

   localparam logic [PIN_LEN_W-1:0] PIN_BYTES = 9'd6;
   localparam logic [COUNT_W-1:0]   COUNT_CAP = 8'hFF;

   localparam logic [MAX_ATT_W-1:0] MAX_ATTEMPTS_RST = 8'd5;
   localparam logic [LOCK_T_W-1:0]  LOCKOUT_TIME_RST = 40'd60000000;

   // access levels; NEED_NONE marks an unsupported characteristic
   localparam logic [LEVEL_W-1:0] LEVEL_0   = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_1   = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_2   = 2'd2;
   localparam logic [LEVEL_W-1:0] NEED_NONE = 2'd3;

   typedef enum logic [CMD_W-1:0] {
      CMD_CONNECT    = 3'd0,
      CMD_DISCONNECT = 3'd1,
      CMD_PIN        = 3'd2,
      CMD_ADMIN      = 3'd3,
      CMD_COMMAND    = 3'd4,
      CMD_ACCESS     = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 3'd0,
      ST_FAIL   = 3'd1,
      ST_LOCKED = 3'd2,
      ST_UNAUTH = 3'd3,
      ST_INSUFF = 3'd4,
      ST_UNSUP  = 3'd5
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_ATTEMPTS   = 3'd0,
      CSR_LOCKOUT_TIME   = 3'd1,
      CSR_PIN_CODE       = 3'd2,
      CSR_RESTART_OPCODE = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [TIME_W-1:0]    now_time;
      logic [PIN_W-1:0]     pin_value;
      logic [PIN_LEN_W-1:0] pin_length;
      logic                 admin_token_ok;
      logic [CODE_W-1:0]    command_code;
      logic [CHAR_W-1:0]    char_index;
      logic                 is_write;
      logic                 link_ok;
   } req_item_type;

   typedef struct packed {
      status_type           status;
      logic                 notify;
      logic [LEVEL_W-1:0]   level_now;
      logic [COUNT_W-1:0]   attempts_now;
      logic                 locked_now;
   } rsp_item_type;

   typedef struct packed {
      logic [MAX_ATT_W-1:0] max_attempts;
      logic [LOCK_T_W-1:0]  lockout_time;
      logic [PIN_W-1:0]     pin_code;
      logic [CODE_W-1:0]    restart_opcode;
   } cfg_type;

   function automatic logic [LEVEL_W-1:0] read_need(input logic [CHAR_W-1:0] idx);
      logic [LEVEL_W-1:0] need;
      case (idx)
         4'd6:                          need = LEVEL_0;
         4'd0, 4'd2, 4'd4, 4'd10, 4'd13: need = LEVEL_1;
         4'd7, 4'd11:                   need = LEVEL_2;
         default:                       need = NEED_NONE;
      endcase
      return need;
   endfunction

   function automatic logic [LEVEL_W-1:0] write_need(input logic [CHAR_W-1:0] idx);
      logic [LEVEL_W-1:0] need;
      case (idx)
         4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd12: need = LEVEL_1;
         4'd11:                                     need = LEVEL_2;
         default:                                   need = LEVEL_0;
      endcase
      return need;
   endfunction

endpackage

/* design/pin_lockout_access_gate_unit.sv */
// Top level of the PIN lockout access gate: input register, decision core, result register.
//
// PIN lockout access gate. Each transfer on the req_ channel is one link event (connect,
// disconnect, PIN attempt, admin attempt, command, characteristic access check) and
// yields exactly one transfer on the rsp_ channel carrying the status, the notify flag
// and the level, wrong-PIN count and lockout flag as they stand after that event.
// Throughput is one event per clock while rsp_stall is low: the event is captured in an
// input register, judged against the gate state, and the answer is parked in a result
// register, so rsp_valid rises once the event has passed through both registers. The
// per-cycle work is set by the 48-bit deadline compare and the 48-bit lockout deadline
// add. While a result waits under rsp_stall a further event is still taken into the
// input register; req_stall rises only when both registers are full and rsp_stall holds
// the result. Configuration (index 0 max_attempts, 1 lockout_time, 2 pin_code,
// 3 restart_opcode; higher indexes ignored) is written through csr_ with no wait, and
// should only be written while no event is in flight.
module pin_lockout_access_gate_unit (
   input  logic                            clock,
   input  logic                            reset,
   // event channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [plag_pkg::CMD_W-1:0]      req_cmd,
   input  logic [plag_pkg::TIME_W-1:0]     req_now_time,
   input  logic [plag_pkg::PIN_W-1:0]      req_pin_value,
   input  logic [plag_pkg::PIN_LEN_W-1:0]  req_pin_length,
   input  logic                            req_admin_token_ok,
   input  logic [plag_pkg::CODE_W-1:0]     req_command_code,
   input  logic [plag_pkg::CHAR_W-1:0]     req_char_index,
   input  logic                            req_is_write,
   input  logic                            req_link_ok,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [plag_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_notify,
   output logic [plag_pkg::LEVEL_W-1:0]    rsp_level_now,
   output logic [plag_pkg::COUNT_W-1:0]    rsp_attempts_now,
   output logic                            rsp_locked_now,
   // configuration write port
   input  logic                            csr_wr_en,
   input  logic [plag_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [plag_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import plag_pkg::*;

   `include "pin_lockout_access_gate_unit_defines.svh"

   cfg_type      cfg;
   req_item_type req_item;
   req_item_type item_ff;
   logic         item_valid_ff, item_valid_in;
   rsp_item_type result;
   rsp_item_type rsp_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         out_free;
   logic         fire;
   logic         req_take;

   assign req_item.cmd            = req_cmd;
   assign req_item.now_time       = req_now_time;
   assign req_item.pin_value      = req_pin_value;
   assign req_item.pin_length     = req_pin_length;
   assign req_item.admin_token_ok = req_admin_token_ok;
   assign req_item.command_code   = req_command_code;
   assign req_item.char_index     = req_char_index;
   assign req_item.is_write       = req_is_write;
   assign req_item.link_ok        = req_link_ok;

   // result register can load when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // the held event is judged and its answer registered
   assign fire      = item_valid_ff && out_free;
   assign req_stall = item_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign item_valid_in = req_take || (item_valid_ff && !fire);
   assign rsp_valid_in  = fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_item;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   plag_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   plag_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_notify       = rsp_ff.notify;
   assign rsp_level_now    = rsp_ff.level_now;
   assign rsp_attempts_now = rsp_ff.attempts_now;
   assign rsp_locked_now   = rsp_ff.locked_now;

   // a judged event always shows up in the result register next cycle
   `PLAG_ASSERT(a_fire_to_rsp, fire |=> rsp_valid_ff, "judged event lost")
   // an event is only taken when the input register is empty or moving on
   `PLAG_ASSERT(a_no_overwrite, (item_valid_ff && !fire) |-> !req_take, "held event overwritten")

endmodule

/* design/plag_csr.sv */
// Configuration registers of the PIN lockout access gate.
module plag_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [plag_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [plag_pkg::CSR_DATA_W-1:0] csr_wdata,
   output plag_pkg::cfg_type             cfg
);
   import plag_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAX_ATTEMPTS:   cfg_in.max_attempts   = csr_wdata[MAX_ATT_W-1:0];
            CSR_LOCKOUT_TIME:   cfg_in.lockout_time   = csr_wdata[LOCK_T_W-1:0];
            CSR_PIN_CODE:       cfg_in.pin_code       = csr_wdata[PIN_W-1:0];
            CSR_RESTART_OPCODE: cfg_in.restart_opcode = csr_wdata[CODE_W-1:0];
            default:            cfg_in = cfg_ff; // indexes past the list are ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_attempts   <= MAX_ATTEMPTS_RST;
         cfg_ff.lockout_time   <= LOCKOUT_TIME_RST;
         cfg_ff.pin_code       <= '0;
         cfg_ff.restart_opcode <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/plag_core.sv */
// Gate state and per-event decision logic of the PIN lockout access gate.
`include "pin_lockout_access_gate_unit_defines.svh"

module plag_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  plag_pkg::req_item_type item,
   input  plag_pkg::cfg_type      cfg,
   output plag_pkg::rsp_item_type result
);
   import plag_pkg::*;

   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               link_ff, link_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [TIME_W-1:0]  deadline_ff, deadline_in;

   logic               lock_set;
   logic               lock_active;
   logic               pin_match;
   logic [COUNT_W-1:0] base_count;
   logic [COUNT_W-1:0] bumped_count;
   logic [TIME_W:0]    lock_sum;
   logic [TIME_W-1:0]  lock_until;
   logic [LEVEL_W-1:0] cmd_need;
   logic [LEVEL_W-1:0] chr_need;
   status_type         status;
   logic               notify;

   assign lock_set    = (deadline_ff != '0);
   assign lock_active = lock_set && (item.now_time < deadline_ff);
   assign pin_match   = (item.pin_length == PIN_BYTES) && (item.pin_value == cfg.pin_code);
   // an expired lockout forgets the old count before this attempt is judged
   assign base_count   = lock_set ? '0 : count_ff;
   assign bumped_count = (base_count == COUNT_CAP) ? COUNT_CAP : base_count + 1'b1;
   assign lock_sum     = {1'b0, item.now_time} + {{(TIME_W + 1 - LOCK_T_W){1'b0}},
                                                   cfg.lockout_time};
   assign lock_until   = lock_sum[TIME_W] ? '1 : lock_sum[TIME_W-1:0];
   assign cmd_need     = (item.command_code == cfg.restart_opcode) ? LEVEL_1 : LEVEL_2;
   assign chr_need     = item.is_write ? write_need(item.char_index)
                                       : read_need(item.char_index);

   always_comb begin
      level_in    = level_ff;
      link_in     = link_ff;
      count_in    = count_ff;
      deadline_in = deadline_ff;
      status      = ST_UNSUP;
      notify      = 1'b0;
      unique case (cmd_type'(item.cmd))
         CMD_CONNECT: begin
            if (item.link_ok) begin
               link_in  = 1'b1;
               level_in = LEVEL_0;
               status   = ST_OK;
            end else begin
               status   = ST_FAIL;
            end
         end
         CMD_DISCONNECT: begin
            link_in  = 1'b0;
            level_in = LEVEL_0;
            status   = ST_OK;
         end
         CMD_PIN: begin
            notify = link_ff;
            if (lock_active) begin
               status = ST_LOCKED;
            end else if (pin_match) begin
               level_in    = LEVEL_1;
               count_in    = '0;
               deadline_in = '0;
               status      = ST_OK;
            end else begin
               count_in = bumped_count;
               if (bumped_count >= cfg.max_attempts) begin
                  deadline_in = lock_until;
                  status      = ST_LOCKED;
               end else begin
                  deadline_in = '0;
                  status      = ST_FAIL;
               end
            end
         end
         CMD_ADMIN: begin
            notify = link_ff;
            if (level_ff < LEVEL_1) begin
               status = ST_UNAUTH;
            end else if (item.admin_token_ok) begin
               level_in = LEVEL_2;
               status   = ST_OK;
            end else begin
               status   = ST_FAIL;
            end
         end
         CMD_COMMAND: begin
            notify = link_ff;
            status = (level_ff < cmd_need) ? ST_UNAUTH : ST_OK;
         end
         CMD_ACCESS: begin
            if (chr_need == NEED_NONE) begin
               status = ST_UNSUP;
            end else if (level_ff < chr_need) begin
               status = ST_INSUFF;
            end else begin
               status = ST_OK;
            end
         end
         default: status = ST_UNSUP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= LEVEL_0;
         link_ff     <= 1'b0;
         count_ff    <= '0;
         deadline_ff <= '0;
      end else if (fire) begin
         level_ff    <= level_in;
         link_ff     <= link_in;
         count_ff    <= count_in;
         deadline_ff <= deadline_in;
      end
   end

   assign result.status       = status;
   assign result.notify       = notify;
   assign result.level_now    = level_in;
   assign result.attempts_now = count_in;
   assign result.locked_now   = (deadline_in != '0);

   // a lockout deadline always comes with a nonzero wrong count
   `PLAG_ASSERT_ALWAYS(a_lock_has_count, (deadline_ff != '0) |-> (count_ff != '0), "deadline without count")
   // an attempt during lockout leaves count and deadline untouched
   `PLAG_ASSERT(a_lock_holds, (fire && item.cmd == CMD_PIN && lock_active) |=> ($stable(count_ff) && $stable(deadline_ff)), "lockout state moved")
   // a matching PIN outside lockout grants level one and clears the count
   `PLAG_ASSERT(a_match_grants, (fire && item.cmd == CMD_PIN && !lock_active && pin_match) |=> (level_ff == LEVEL_1 && count_ff == '0 && deadline_ff == '0), "PIN match not granted")

endmodule
